FILE: sv/spft_pkg.sv
// ----------------------------------------------------------------------------
// spft_pkg
// Shared widths, types and helpers for the symbolic Pauli frame tracker.
// ----------------------------------------------------------------------------
package spft_pkg;

  localparam int MASK_W      = 64;   // qubit mask width
  localparam int SYM_W       = 64;   // symbol mask width
  localparam int CNT_W       = 7;    // width of a count register
  localparam int MAX_QUBITS  = 64;
  localparam int MAX_SYMBOLS = 64;

  // configuration register indexes
  localparam logic REG_QUBITS  = 1'b0;
  localparam logic REG_SYMBOLS = 1'b1;

  // commands
  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SYM = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);

  // item control broadcast to all cells while the item walks the chain
  typedef struct packed {
    logic             apply;
    logic             cond_c;
    logic [SYM_W-1:0] cond_s;
  } spft_ctl_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             acc_c;
    logic [SYM_W-1:0] acc_s;
  } spft_token_t;

  // low mask with bit i set for i < min(count, limit)
  function automatic logic [MASK_W-1:0] low_mask(input logic [CNT_W-1:0] count,
                                                 input int limit);
    logic [MASK_W-1:0] m;
    int                n;
    n = (int'(count) > limit) ? limit : int'(count);
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

endpackage

FILE: sv/spft_cell.sv
// ----------------------------------------------------------------------------
// spft_cell
// One qubit of the frame: holds its X and Z rows and updates or reads them
// as the item token passes through.
// ----------------------------------------------------------------------------
module spft_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  spft_pkg::spft_ctl_t   ctl,
  input  logic                  sel_x,
  input  logic                  sel_z,
  input  spft_pkg::spft_token_t tok_in,
  output spft_pkg::spft_token_t tok_out
);

  logic [spft_pkg::SYM_W-1:0] x_sym;
  logic [spft_pkg::SYM_W-1:0] z_sym;
  logic                       x_c;
  logic                       z_c;
  spft_pkg::spft_token_t      tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active && !ctl.apply) begin
      // sign: Z rows of X support, X rows of Z support
      tok_next.acc_s = tok_in.acc_s ^ (sel_x ? z_sym : '0) ^ (sel_z ? x_sym : '0);
      tok_next.acc_c = tok_in.acc_c ^ (sel_x & z_c) ^ (sel_z & x_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_sym   <= '0;
      z_sym   <= '0;
      x_c     <= 1'b0;
      z_c     <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.active && ctl.apply) begin
        if (sel_x) begin
          x_sym <= x_sym ^ ctl.cond_s;
          x_c   <= x_c ^ ctl.cond_c;
        end
        if (sel_z) begin
          z_sym <= z_sym ^ ctl.cond_s;
          z_c   <= z_c ^ ctl.cond_c;
        end
      end
    end
  end

endmodule

FILE: sv/symbolic_pauli_frame_tracker_top.sv
// ----------------------------------------------------------------------------
// symbolic_pauli_frame_tracker_top
// Symbolic Pauli frame: per-qubit affine X/Z rows, conditional corrections
// and observable sign queries.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  in       | in_valid / in_stall   | command, pauli_x_mask, pauli_z_mask,
//           |                       | cond_constant, cond_symbols
//  out      | out_valid / out_stall | status, sign_constant, sign_symbols
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  An item walks a chain of MAX_QUBITS cells, one cell per cycle, and its
//  result goes to the pending register; an apply with an out-of-range
//  symbol is answered without entering the chain.
//  One item is in flight at a time; the next is taken while a result waits.
//  Synchronous reset clears all rows and sets both counts to 64.
//  A stalled result holds in the output register and a second one in the
//  pending register; input stalls until the pending slot empties.
// ----------------------------------------------------------------------------
module symbolic_pauli_frame_tracker_top #(
  parameter int MAX_QUBITS = spft_pkg::MAX_QUBITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [spft_pkg::MASK_W-1:0]   pauli_x_mask,
  input  logic [spft_pkg::MASK_W-1:0]   pauli_z_mask,
  input  logic                          cond_constant,
  input  logic [spft_pkg::SYM_W-1:0]    cond_symbols,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic                          sign_constant,
  output logic [spft_pkg::SYM_W-1:0]    sign_symbols,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [spft_pkg::CNT_W-1:0]    cfg_data
);

  logic [spft_pkg::CNT_W-1:0]  qubits_in_use;
  logic [spft_pkg::CNT_W-1:0]  symbols_in_use;

  spft_pkg::spft_ctl_t         ctl;
  logic [MAX_QUBITS-1:0]       xm;
  logic [MAX_QUBITS-1:0]       zm;
  logic                        launch;
  logic                        running;

  logic                        pend_valid;
  logic                        pend_status;
  logic                        pend_c;
  logic [spft_pkg::SYM_W-1:0]  pend_s;

  spft_pkg::spft_token_t       tok [MAX_QUBITS+1];
  logic [MAX_QUBITS:0]         tok_active;

  logic                        in_accept;
  logic                        bad_sym;
  logic                        out_free;
  logic [spft_pkg::MASK_W-1:0] qmask;
  logic [spft_pkg::SYM_W-1:0]  smask;

  assign cfg_ready = 1'b1;
  assign in_stall  = running | pend_valid;
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;

  assign qmask   = spft_pkg::low_mask(qubits_in_use, MAX_QUBITS);
  assign smask   = spft_pkg::low_mask(symbols_in_use, spft_pkg::MAX_SYMBOLS);
  assign bad_sym = (command == spft_pkg::CMD_APPLY) && ((cond_symbols & ~smask) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      qubits_in_use  <= spft_pkg::COUNT_RESET;
      symbols_in_use <= spft_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spft_pkg::REG_QUBITS:  qubits_in_use  <= cfg_data;
        spft_pkg::REG_SYMBOLS: symbols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch the item; masks are clipped to the tracked qubits here
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ctl.apply  <= (command == spft_pkg::CMD_APPLY);
      ctl.cond_c <= cond_constant;
      ctl.cond_s <= cond_symbols;
      xm         <= MAX_QUBITS'(pauli_x_mask & qmask);
      zm         <= MAX_QUBITS'(pauli_z_mask & qmask);
    end
  end

  always_comb begin
    tok[0]        = '0;
    tok[0].active = launch;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_QUBITS; g++) begin : g_cell
      spft_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .sel_x   (xm[g]),
        .sel_z   (zm[g]),
        .tok_in  (tok[g]),
        .tok_out (tok[g+1])
      );
    end
    for (g = 0; g <= MAX_QUBITS; g++) begin : g_act
      assign tok_active[g] = tok[g].active;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      launch     <= 1'b0;
      running    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      launch <= in_accept & ~bad_sym;
      if (in_accept && !bad_sym) begin
        running <= 1'b1;
      end else if (tok[MAX_QUBITS].active) begin
        running <= 1'b0;
      end

      // drop a rejected apply straight into the pending slot
      if (in_accept && bad_sym) begin
        pend_valid  <= 1'b1;
        pend_status <= spft_pkg::STATUS_BAD_SYM;
        pend_c      <= 1'b0;
        pend_s      <= '0;
      end else if (tok[MAX_QUBITS].active) begin
        pend_valid  <= 1'b1;
        pend_status <= spft_pkg::STATUS_OK;
        pend_c      <= tok[MAX_QUBITS].acc_c;
        pend_s      <= tok[MAX_QUBITS].acc_s;
      end else if (pend_valid && out_free) begin
        pend_valid <= 1'b0;
      end

      if (pend_valid && out_free) begin
        out_valid     <= 1'b1;
        status        <= pend_status;
        sign_constant <= pend_c;
        sign_symbols  <= pend_s;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("item accepted without marking the block busy");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_active))
    else $error("more than one item token in the cell chain");

  a_tail_pend: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_QUBITS].active |-> !pend_valid)
    else $error("chain result arrived while pending slot is full");

  a_tail_running: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_QUBITS].active |-> running)
    else $error("chain result without an item in flight");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for symbolic_pauli_frame_tracker_top. A short table of directed
// items and register writes runs first, then phases of random corrections and
// sign queries under several qubit and symbol counts. Every result is checked
// in order against an in-bench model of the per-qubit affine X/Z rows, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic                       cmd;
    logic [spft_pkg::MASK_W-1:0] xm;
    logic [spft_pkg::MASK_W-1:0] zm;
    logic                       cc;
    logic [spft_pkg::SYM_W-1:0] cs;
  } frame_item_t;

  typedef struct packed {
    logic                       st;
    logic                       sc;
    logic [spft_pkg::SYM_W-1:0] ss;
  } sign_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    frame_item_t                item;
    sign_result_t               want;
    logic                       idx;
    logic [spft_pkg::CNT_W-1:0] val;
  } table_row_t;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] NO_BITS  = '0;
  localparam logic [63:0] BIT0     = 64'd1;
  localparam logic [63:0] BIT63    = 64'd1 << 63;
  localparam sign_result_t RES_OK  = '{spft_pkg::STATUS_OK, 1'b0, 64'd0};
  localparam sign_result_t RES_BAD = '{spft_pkg::STATUS_BAD_SYM, 1'b0, 64'd0};
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 205;
  localparam int HOLD_LEN   = 300;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          command = 1'b0;
  logic [spft_pkg::MASK_W-1:0]   pauli_x_mask = '0;
  logic [spft_pkg::MASK_W-1:0]   pauli_z_mask = '0;
  logic                          cond_constant = 1'b0;
  logic [spft_pkg::SYM_W-1:0]    cond_symbols = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          status;
  logic                          sign_constant;
  logic [spft_pkg::SYM_W-1:0]    sign_symbols;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_index = 1'b0;
  logic [spft_pkg::CNT_W-1:0]    cfg_data = '0;

  // model of the frame
  logic [spft_pkg::SYM_W-1:0] x_frame_sym [spft_pkg::MAX_QUBITS] = '{default: '0};
  logic [spft_pkg::SYM_W-1:0] z_frame_sym [spft_pkg::MAX_QUBITS] = '{default: '0};
  logic                       x_frame_const [spft_pkg::MAX_QUBITS] = '{default: 1'b0};
  logic                       z_frame_const [spft_pkg::MAX_QUBITS] = '{default: 1'b0};
  logic [spft_pkg::CNT_W-1:0] qubit_count = spft_pkg::COUNT_RESET;
  logic [spft_pkg::CNT_W-1:0] symbol_count = spft_pkg::COUNT_RESET;

  sign_result_t        awaited_signs[$];
  table_row_t          directed_rows[$];
  int                  err_count = 0;
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;

  symbolic_pauli_frame_tracker_top u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #25000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] count_mask(input logic [spft_pkg::CNT_W-1:0] n);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) m[i] = (i < n);
    return m;
  endfunction

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(7))
      0: return NO_BITS;
      1: return ALL_ONES;
      2: return BIT0 << $urandom_range(63);
      3, 4: return {$urandom, $urandom};
      5: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // append to the tail of the expected results
  task automatic await_sign(input sign_result_t r);
    awaited_signs.insert(awaited_signs.size(), r);
  endtask

  task automatic add_row(input table_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // advance the frame model by one item and return its result
  task automatic track_frame(input frame_item_t it, output sign_result_t r);
    logic [63:0] xm;
    logic [63:0] zm;
    logic [63:0] acc;
    logic        cst;
    xm  = it.xm & count_mask(qubit_count);
    zm  = it.zm & count_mask(qubit_count);
    acc = '0;
    cst = 1'b0;
    r   = RES_OK;
    if (it.cmd == spft_pkg::CMD_APPLY) begin
      if ((it.cs & ~count_mask(symbol_count)) != '0) begin
        r.st = spft_pkg::STATUS_BAD_SYM;
      end else begin
        for (int q = 0; q < spft_pkg::MAX_QUBITS; q++) begin
          if (xm[q]) begin
            x_frame_sym[q]   ^= it.cs;
            x_frame_const[q] ^= it.cc;
          end
          if (zm[q]) begin
            z_frame_sym[q]   ^= it.cs;
            z_frame_const[q] ^= it.cc;
          end
        end
      end
    end else begin
      for (int q = 0; q < spft_pkg::MAX_QUBITS; q++) begin
        if (xm[q]) begin
          acc ^= z_frame_sym[q];
          cst ^= z_frame_const[q];
        end
        if (zm[q]) begin
          acc ^= x_frame_sym[q];
          cst ^= x_frame_const[q];
        end
      end
      r.sc = cst;
      r.ss = acc;
    end
  endtask

  // offer one item, hold it until taken, then maybe idle
  task automatic offer(input frame_item_t it, input bit known, input sign_result_t want);
    sign_result_t r;
    in_valid      <= 1'b1;
    command       <= it.cmd;
    pauli_x_mask  <= it.xm;
    pauli_z_mask  <= it.zm;
    cond_constant <= it.cc;
    cond_symbols  <= it.cs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_frame(it, r);
    await_sign(known ? want : r);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_signs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [spft_pkg::CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == spft_pkg::REG_QUBITS) qubit_count = val;
    else symbol_count = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic table_row_t row_item(input logic cmd, input logic [63:0] xm,
                                          input logic [63:0] zm, input logic cc,
                                          input logic [63:0] cs);
    return '{ROW_ITEM, '{cmd, xm, zm, cc, cs}, RES_OK, 1'b0, '0};
  endfunction

  function automatic table_row_t row_known(input logic cmd, input logic [63:0] xm,
                                           input logic [63:0] zm, input logic cc,
                                           input logic [63:0] cs, input sign_result_t want);
    return '{ROW_KNOWN, '{cmd, xm, zm, cc, cs}, want, 1'b0, '0};
  endfunction

  function automatic table_row_t row_reg(input logic idx,
                                         input logic [spft_pkg::CNT_W-1:0] val);
    return '{ROW_REG, '0, RES_OK, idx, val};
  endfunction

  // receiver: random stalls, a calm stretch, and one long hold-off
  initial begin : rx_side
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  always @(posedge clk) begin : check_results
    sign_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_signs.size() == 0) begin
        report_mismatch("unexpected result", sign_symbols, '0);
      end else begin
        want = awaited_signs.pop_front();
        if (status !== want.st)
          report_mismatch("status", 64'(status), 64'(want.st));
        if (sign_constant !== want.sc)
          report_mismatch("sign_constant", 64'(sign_constant), 64'(want.sc));
        if (sign_symbols !== want.ss)
          report_mismatch("sign_symbols", sign_symbols, want.ss);
      end
    end
  end

  initial begin : stimulus
    frame_item_t it;
    int          q_plan[6];
    int          s_plan[6];
    int          pick;
    q_plan = '{64, 1, 127, 3, 37, 64};
    s_plan = '{64, 0, 127, 5, 63, 1};

    // fresh frame, full mask extremes
    add_row(row_known(spft_pkg::CMD_QUERY, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, RES_OK));
    add_row(row_known(spft_pkg::CMD_APPLY, ALL_ONES, NO_BITS, 1'b1, BIT63 | BIT0, RES_OK));
    add_row(row_known(spft_pkg::CMD_APPLY, NO_BITS, ALL_ONES, 1'b0, ALL_ONES, RES_OK));
    add_row(row_known(spft_pkg::CMD_APPLY, NO_BITS, NO_BITS, 1'b1, ALL_ONES, RES_OK));
    // condition fields are ignored on a query
    add_row(row_item(spft_pkg::CMD_QUERY, BIT0, NO_BITS, 1'b1, ALL_ONES));
    add_row(row_item(spft_pkg::CMD_QUERY, NO_BITS, BIT63, 1'b0, NO_BITS));
    add_row(row_item(spft_pkg::CMD_QUERY, ALL_ONES, ALL_ONES, 1'b0, 64'h5a5a));
    // narrow symbol range: rejection, and old high bits still read back
    add_row(row_reg(spft_pkg::REG_SYMBOLS, 7'd8));
    add_row(row_known(spft_pkg::CMD_APPLY, ALL_ONES, ALL_ONES, 1'b1, BIT0 << 8, RES_BAD));
    add_row(row_known(spft_pkg::CMD_APPLY, 64'h5, 64'h3, 1'b1, 64'hff, RES_OK));
    add_row(row_item(spft_pkg::CMD_QUERY, NO_BITS, BIT0, 1'b0, NO_BITS));
    // no symbols: only an empty condition passes
    add_row(row_reg(spft_pkg::REG_SYMBOLS, 7'd0));
    add_row(row_known(spft_pkg::CMD_APPLY, BIT63, BIT0, 1'b1, NO_BITS, RES_OK));
    add_row(row_known(spft_pkg::CMD_APPLY, BIT63, BIT0, 1'b1, BIT0, RES_BAD));
    // symbol count above the maximum saturates
    add_row(row_reg(spft_pkg::REG_SYMBOLS, 7'd127));
    add_row(row_known(spft_pkg::CMD_APPLY, 64'hf0f0, 64'h0ff0, 1'b0, ALL_ONES, RES_OK));
    // no qubits tracked
    add_row(row_reg(spft_pkg::REG_QUBITS, 7'd0));
    add_row(row_known(spft_pkg::CMD_APPLY, ALL_ONES, ALL_ONES, 1'b1, 64'hdead, RES_OK));
    add_row(row_known(spft_pkg::CMD_QUERY, ALL_ONES, ALL_ONES, 1'b0, NO_BITS, RES_OK));
    add_row(row_reg(spft_pkg::REG_QUBITS, 7'd1));
    add_row(row_known(spft_pkg::CMD_APPLY, ALL_ONES, ALL_ONES, 1'b1, 64'hbeef, RES_OK));
    add_row(row_item(spft_pkg::CMD_QUERY, ALL_ONES, NO_BITS, 1'b0, NO_BITS));
    // excluded qubits keep their rows until the count rises again
    add_row(row_reg(spft_pkg::REG_QUBITS, 7'd40));
    add_row(row_item(spft_pkg::CMD_APPLY, BIT0 << 40 | BIT0 << 39, BIT0 << 41, 1'b1,
                     64'h1234_5678_9abc_def0));
    add_row(row_reg(spft_pkg::REG_QUBITS, 7'd127));
    add_row(row_item(spft_pkg::CMD_QUERY, ALL_ONES, ALL_ONES, 1'b0, NO_BITS));
    add_row(row_item(spft_pkg::CMD_QUERY, BIT0 << 63 | BIT0 << 40, NO_BITS, 1'b0, NO_BITS));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_REG: begin
          settle();
          write_reg(directed_rows[i].idx, directed_rows[i].val);
        end
        ROW_KNOWN: offer(directed_rows[i].item, 1'b1, directed_rows[i].want);
        default: offer(directed_rows[i].item, 1'b0, RES_OK);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(spft_pkg::REG_QUBITS, (p < 6) ? spft_pkg::CNT_W'(q_plan[p])
                                              : spft_pkg::CNT_W'($urandom_range(127)));
      write_reg(spft_pkg::REG_SYMBOLS, (p < 6) ? spft_pkg::CNT_W'(s_plan[p])
                                               : spft_pkg::CNT_W'($urandom_range(127)));
      calm = (p == 4);
      // long output hold-off while items keep coming
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick  = $urandom_range(99);
        it.xm = rand_mask();
        it.zm = rand_mask();
        it.cc = 1'($urandom_range(1));
        if (pick < 35) begin
          it.cmd = spft_pkg::CMD_QUERY;
          it.cs  = rand_mask();
        end else if (pick < 90) begin
          it.cmd = spft_pkg::CMD_APPLY;
          it.cs  = rand_mask() & count_mask(symbol_count);
        end else begin
          it.cmd = spft_pkg::CMD_APPLY;
          it.cs  = rand_mask() | (BIT0 << $urandom_range(63));
        end
        offer(it, 1'b0, RES_OK);
      end
      calm = 1'b0;
    end

    settle();
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
